/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the decoder.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* rtl/ps2dec_pkg.sv */
// Types and constants of the PS/2 set 2 scan code decoder.
// No dependencies; imported by every module of the decoder.
package ps2dec_pkg;

  // Bytes kept for the sequence in progress (the eighth byte is never stored).
  localparam int unsigned SeqDepth = 7;
  localparam int unsigned LenWidth = 3;

  // Highest accepted code plus one, for plain and for E0-prefixed keys.
  localparam int unsigned NormalCodeLimit   = 256;
  localparam int unsigned ExtendedCodeLimit = 256;

  localparam logic [7:0] BytePrefixBreak = 8'hF0;
  localparam logic [7:0] BytePrefixExt   = 8'hE0;
  localparam logic [7:0] BytePrefixPause = 8'hE1;
  localparam logic [7:0] BytePrtScLead   = 8'h12;
  localparam logic [7:0] BytePrtScCode   = 8'h7C;
  localparam logic [7:0] BytePauseCtrl   = 8'h14;
  localparam logic [7:0] BytePauseNum    = 8'h77;

  typedef enum logic [2:0] {
    KIND_INCOMPLETE = 3'd0,
    KIND_NORMAL     = 3'd1,
    KIND_EXTENDED   = 3'd2,
    KIND_PRINT      = 3'd3,
    KIND_PAUSE      = 3'd4,
    KIND_UNKNOWN    = 3'd5
  } event_kind_e;

  typedef logic [SeqDepth-1:0][7:0] seq_bytes_t;

  // Decision for one byte: the event plus the sequence clear request.
  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  code;
    logic        pressed;
    logic        pulse;
    logic        clear;
  } dec_result_t;

endpackage

/* rtl/ps2dec_seq_store.sv */
// Byte store and length counter for the scan sequence in progress.
// Depends on ps2dec_pkg.
module ps2dec_seq_store (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                write_en_i,
  input  logic                                clear_i,
  input  logic [7:0]                          scan_byte_i,
  output logic [ps2dec_pkg::LenWidth-1:0]     seq_len_o,
  output ps2dec_pkg::seq_bytes_t              seq_bytes_o
);
  import ps2dec_pkg::*;

  logic [LenWidth-1:0] len_q, len_d;
  seq_bytes_t          bytes_q;

  always_comb begin
    len_d = len_q;
    if (write_en_i) begin
      len_d = clear_i ? '0 : len_q + LenWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  // Last byte of a full sequence is decoded straight from the input: skip it.
  always_ff @(posedge clk_i) begin
    if (write_en_i && (len_q != LenWidth'(SeqDepth))) begin
      bytes_q[len_q] <= scan_byte_i;
    end
  end

  assign seq_len_o   = len_q;
  assign seq_bytes_o = bytes_q;

endmodule

/* rtl/ps2dec_classify.sv */
// Combinational classifier: stored sequence plus current byte to one event.
// Depends on ps2dec_pkg.
module ps2dec_classify (
  input  logic [ps2dec_pkg::LenWidth-1:0] seq_len_i,
  input  ps2dec_pkg::seq_bytes_t          seq_bytes_i,
  input  logic [7:0]                      scan_byte_i,
  output ps2dec_pkg::dec_result_t         result_o
);
  import ps2dec_pkg::*;

  function automatic dec_result_t finish_key(event_kind_e kind, logic [7:0] code,
                                             logic pressed, logic [8:0] limit);
    dec_result_t r;
    r       = '0;
    r.clear = 1'b1;
    if ({1'b0, code} >= limit) begin
      r.kind = KIND_UNKNOWN;
    end else begin
      r.kind    = kind;
      r.code    = code;
      r.pressed = pressed;
    end
    return r;
  endfunction

  localparam logic [8:0] NormLimit = 9'(NormalCodeLimit);
  localparam logic [8:0] ExtLimit  = 9'(ExtendedCodeLimit);

  dec_result_t wait_res;
  dec_result_t unknown_res;
  logic [7:0]  b;
  logic        prt_make, prt_break, pause_hit;

  assign b = scan_byte_i;

  always_comb begin
    wait_res          = '0;
    wait_res.kind     = KIND_INCOMPLETE;
    unknown_res       = '0;
    unknown_res.kind  = KIND_UNKNOWN;
    unknown_res.clear = 1'b1;
  end

  // Long-sequence matches; the current byte closes each pattern.
  assign prt_make  = (seq_bytes_i[0] == BytePrefixExt) && (seq_bytes_i[1] == BytePrtScLead) &&
                     (seq_bytes_i[2] == BytePrefixExt) && (b == BytePrtScCode);
  assign prt_break = (seq_len_i == LenWidth'(5)) &&
                     (seq_bytes_i[0] == BytePrefixExt) && (seq_bytes_i[1] == BytePrefixBreak) &&
                     (seq_bytes_i[2] == BytePrtScCode) && (seq_bytes_i[3] == BytePrefixExt) &&
                     (seq_bytes_i[4] == BytePrefixBreak) && (b == BytePrtScLead);
  assign pause_hit = (seq_bytes_i[0] == BytePrefixPause) && (seq_bytes_i[1] == BytePauseCtrl) &&
                     (seq_bytes_i[2] == BytePauseNum) && (seq_bytes_i[3] == BytePrefixPause) &&
                     (seq_bytes_i[4] == BytePrefixBreak) && (seq_bytes_i[5] == BytePauseCtrl) &&
                     (seq_bytes_i[6] == BytePrefixBreak) && (b == BytePauseNum);

  always_comb begin
    result_o = wait_res;
    unique case (seq_len_i)
      LenWidth'(0): begin
        if ((b == BytePrefixBreak) || (b == BytePrefixExt) || (b == BytePrefixPause)) begin
          result_o = wait_res;
        end else begin
          result_o = finish_key(KIND_NORMAL, b, 1'b1, NormLimit);
        end
      end
      LenWidth'(1): begin
        if (seq_bytes_i[0] == BytePrefixBreak) begin
          result_o = finish_key(KIND_NORMAL, b, 1'b0, NormLimit);
        end else if (seq_bytes_i[0] == BytePrefixExt) begin
          if ((b == BytePrefixBreak) || (b == BytePrtScLead)) begin
            result_o = wait_res;
          end else begin
            result_o = finish_key(KIND_EXTENDED, b, 1'b1, ExtLimit);
          end
        end else begin
          result_o = wait_res;
        end
      end
      LenWidth'(2): begin
        if ((seq_bytes_i[0] == BytePrefixExt) && (seq_bytes_i[1] == BytePrefixBreak)) begin
          if (b == BytePrtScCode) begin
            result_o = wait_res;
          end else begin
            result_o = finish_key(KIND_EXTENDED, b, 1'b0, ExtLimit);
          end
        end else if (((seq_bytes_i[0] == BytePrefixExt) && (seq_bytes_i[1] == BytePrtScLead) &&
                      (b == BytePrefixExt)) ||
                     ((seq_bytes_i[0] == BytePrefixPause) && (seq_bytes_i[1] == BytePauseCtrl) &&
                      (b == BytePauseNum))) begin
          result_o = wait_res;
        end else begin
          result_o = unknown_res;
        end
      end
      default: begin
        if (prt_make) begin
          result_o         = '0;
          result_o.kind    = KIND_PRINT;
          result_o.pressed = 1'b1;
          result_o.clear   = 1'b1;
        end else if (prt_break) begin
          result_o       = '0;
          result_o.kind  = KIND_PRINT;
          result_o.clear = 1'b1;
        end else if (seq_len_i == LenWidth'(SeqDepth)) begin
          if (pause_hit) begin
            result_o       = '0;
            result_o.kind  = KIND_PAUSE;
            result_o.pulse = 1'b1;
            result_o.clear = 1'b1;
          end else begin
            result_o = unknown_res;
          end
        end else begin
          result_o = wait_res;
        end
      end
    endcase
  end

endmodule

/* rtl/ps2_set2_scan_code_decoder_top.sv */
// Top level of the PS/2 scan code set 2 decoder: input register, classifier,
// sequence store and result register. Depends on ps2dec_pkg, ps2dec_classify
// and ps2dec_seq_store.
//
//   channel | valid      | ready      | payload
//   --------+------------+------------+-------------------------------------------
//   in      | in_valid_i | in_ready_o | scan_byte_i
//   out     | out_valid_o| out_ready_i| event_kind_o, key_scan_code_o,
//           |            |            | key_pressed_o, pulse_event_o
//
// Every request in gives exactly one result out, through the input register and
// then the result register; one byte per cycle is sustained while the output is
// not stalled.
// The throughput is set by the single classify pass between the input register
// and the result register, which also advances the sequence store.
// Reset (rst_ni low, asynchronous) empties both registers and clears the
// sequence length; the stored bytes are not cleared.
// While the output stalls, a request is still taken into an empty input
// register; the input then holds until the result register drains.
module ps2_set2_scan_code_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] event_kind_o,
  output logic [7:0] key_scan_code_o,
  output logic       key_pressed_o,
  output logic       pulse_event_o
);
  import ps2dec_pkg::*;

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;

  // Result register.
  logic        out_valid_q, out_valid_d;
  event_kind_e out_kind_q;
  logic [7:0]  out_code_q;
  logic        out_pressed_q;
  logic        out_pulse_q;

  logic                advance;   // result register can take a new value
  logic                take;      // input request moves into the result register
  logic [LenWidth-1:0] seq_len;
  seq_bytes_t          seq_bytes;
  dec_result_t         dec;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign take       = in_valid_q && advance;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
    if (advance) begin
      out_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: load the byte on acceptance, load the event when it advances.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= scan_byte_i;
    end
    if (take) begin
      out_kind_q    <= dec.kind;
      out_code_q    <= dec.code;
      out_pressed_q <= dec.pressed;
      out_pulse_q   <= dec.pulse;
    end
  end

  ps2dec_seq_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .write_en_i  (take),
    .clear_i     (dec.clear),
    .scan_byte_i (in_byte_q),
    .seq_len_o   (seq_len),
    .seq_bytes_o (seq_bytes)
  );

  ps2dec_classify u_classify (
    .seq_len_i   (seq_len),
    .seq_bytes_i (seq_bytes),
    .scan_byte_i (in_byte_q),
    .result_o    (dec)
  );

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = out_kind_q;
  assign key_scan_code_o = out_code_q;
  assign key_pressed_o   = out_pressed_q;
  assign pulse_event_o   = out_pulse_q;

endmodule

/* rtl/ps2dec_checker.sv */
// Port-level checker for the decoder top level, bound into every instance.
// Depends on ps2dec_pkg and assert_macros.svh.
module ps2dec_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] event_kind_o,
  input logic [7:0] key_scan_code_o,
  input logic       key_pressed_o,
  input logic       pulse_event_o
);
  import ps2dec_pkg::*;
  `include "assert_macros.svh"

  // A stalled result holds its event.
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(event_kind_o) && $stable(key_scan_code_o))

  // A pulse flag only ever comes with the pause event.
  `ASSERT_IMP(a_pulse_pause, clk_i, rst_ni, out_valid_o && pulse_event_o, event_kind_o == KIND_PAUSE)

  // Only normal and extended keys carry a scan code.
  `ASSERT_IMP(a_code_kind, clk_i, rst_ni, out_valid_o && (event_kind_o != KIND_NORMAL) && (event_kind_o != KIND_EXTENDED), key_scan_code_o == 8'h00)

  // A make flag needs a key event or print screen.
  `ASSERT_IMP(a_press_kind, clk_i, rst_ni, out_valid_o && key_pressed_o, (event_kind_o == KIND_NORMAL) || (event_kind_o == KIND_EXTENDED) || (event_kind_o == KIND_PRINT))

  // An empty pipeline always takes a request.
  `ASSERT_IMP(a_ready_empty, clk_i, rst_ni, !out_valid_o && !$past(in_valid_i && in_ready_o), in_ready_o)

endmodule

bind ps2_set2_scan_code_decoder_top ps2dec_checker u_ps2dec_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .event_kind_o    (event_kind_o),
  .key_scan_code_o (key_scan_code_o),
  .key_pressed_o   (key_pressed_o),
  .pulse_event_o   (pulse_event_o)
);

/* tb/tb.sv */
// Self-checking testbench for ps2_set2_scan_code_decoder_top: streams scan
// bytes into the decoder and checks every decoded event against a predictor.
// Depends on ps2dec_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module tb;
  import ps2dec_pkg::*;

  localparam int unsigned PlanBytes  = 1850;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned TailCycles = 8;

  // One decoded event as seen on the output channel.
  typedef struct {
    event_kind_e kind;
    logic [7:0]  code;
    logic        pressed;
    logic        pulse;
  } key_event_t;

  // Predicts the event for each accepted scan byte and checks the decoder's
  // results in order against the oldest pending prediction.
  class key_event_board;
    logic [7:0]  held_bytes [8];
    logic [2:0]  held_len;
    key_event_t  pending_events [$];
    int unsigned mismatches;
    int unsigned bytes_seen;
    int unsigned events_checked;
    int unsigned kind_total [6];

    function new();
      foreach (held_bytes[i]) held_bytes[i] = 8'h00;
      held_len = '0;
      mismatches = 0;
      bytes_seen = 0;
      events_checked = 0;
      foreach (kind_total[i]) kind_total[i] = 0;
    endfunction

    function int unsigned pending_count();
      return pending_events.size();
    endfunction

    // Close a normal or extended key: clear the sequence, range-check the code.
    function key_event_t close_key(event_kind_e kind, logic [7:0] code, logic pressed);
      key_event_t ev;
      int unsigned limit;
      limit = (kind == KIND_NORMAL) ? NormalCodeLimit : ExtendedCodeLimit;
      held_len = '0;
      if (int'(code) >= limit) ev = '{KIND_UNKNOWN, 8'h00, 1'b0, 1'b0};
      else ev = '{kind, code, pressed, 1'b0};
      return ev;
    endfunction

    function void note_byte(logic [7:0] b);
      key_event_t  ev;
      int unsigned n;
      ev = '{KIND_INCOMPLETE, 8'h00, 1'b0, 1'b0};
      held_bytes[held_len] = b;
      n = int'(held_len) + 1;
      held_len = n[2:0];
      bytes_seen++;

      if (n == 1) begin
        if (b != BytePrefixBreak && b != BytePrefixExt && b != BytePrefixPause)
          ev = close_key(KIND_NORMAL, b, 1'b1);
      end else if (n == 2) begin
        if (held_bytes[0] == BytePrefixBreak) begin
          ev = close_key(KIND_NORMAL, b, 1'b0);
        end else if (held_bytes[0] == BytePrefixExt) begin
          if (b != BytePrefixBreak && b != BytePrtScLead)
            ev = close_key(KIND_EXTENDED, b, 1'b1);
        end
      end else if (n == 3) begin
        if (held_bytes[0] == BytePrefixExt && held_bytes[1] == BytePrefixBreak) begin
          if (b != BytePrtScCode) ev = close_key(KIND_EXTENDED, b, 1'b0);
        end else if (!((held_bytes[0] == BytePrefixExt && held_bytes[1] == BytePrtScLead &&
                        b == BytePrefixExt) ||
                       (held_bytes[0] == BytePrefixPause && held_bytes[1] == BytePauseCtrl &&
                        b == BytePauseNum))) begin
          held_len = '0;
          ev = '{KIND_UNKNOWN, 8'h00, 1'b0, 1'b0};
        end
      end else if (held_bytes[0] == BytePrefixExt && held_bytes[1] == BytePrtScLead &&
                   held_bytes[2] == BytePrefixExt && b == BytePrtScCode) begin
        held_len = '0;
        ev = '{KIND_PRINT, 8'h00, 1'b1, 1'b0};
      end else if (n == 6 && held_bytes[0] == BytePrefixExt &&
                   held_bytes[1] == BytePrefixBreak && held_bytes[2] == BytePrtScCode &&
                   held_bytes[3] == BytePrefixExt && held_bytes[4] == BytePrefixBreak &&
                   held_bytes[5] == BytePrtScLead) begin
        held_len = '0;
        ev = '{KIND_PRINT, 8'h00, 1'b0, 1'b0};
      end else if (n == 8) begin
        held_len = '0;
        if (held_bytes[0] == BytePrefixPause && held_bytes[1] == BytePauseCtrl &&
            held_bytes[2] == BytePauseNum && held_bytes[3] == BytePrefixPause &&
            held_bytes[4] == BytePrefixBreak && held_bytes[5] == BytePauseCtrl &&
            held_bytes[6] == BytePrefixBreak && held_bytes[7] == BytePauseNum)
          ev = '{KIND_PAUSE, 8'h00, 1'b0, 1'b1};
        else
          ev = '{KIND_UNKNOWN, 8'h00, 1'b0, 1'b0};
      end
      pending_events.push_back(ev);
    endfunction

    function void check_event(logic [2:0] kind, logic [7:0] code, logic pressed,
                              logic pulse);
      key_event_t want;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request pending: kind=%0d code=%02h pressed=%b pulse=%b",
                   $realtime, kind, code, pressed, pulse);
        return;
      end
      want = pending_events.pop_front();
      events_checked++;
      kind_total[want.kind]++;
      if (kind !== want.kind || code !== want.code || pressed !== want.pressed ||
          pulse !== want.pulse) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: event %0d mismatch: expected kind=%0d code=%02h pressed=%b pulse=%b, got kind=%0d code=%02h pressed=%b pulse=%b",
                   $realtime, events_checked, want.kind, want.code, want.pressed, want.pulse,
                   kind, code, pressed, pulse);
      end
    endfunction
  endclass

  // Inputs of the decoder hold known values from time zero.
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] scan_byte_i = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [2:0] event_kind_o;
  logic [7:0] key_scan_code_o;
  logic       key_pressed_o;
  logic       pulse_event_o;

  key_event_board board = new();
  logic [7:0]     scan_plan [$];
  int unsigned    idle_cycles = 0;

  ps2_set2_scan_code_decoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .scan_byte_i    (scan_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .key_scan_code_o(key_scan_code_o),
    .key_pressed_o  (key_pressed_o),
    .pulse_event_o  (pulse_event_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Append a byte sequence to the stimulus plan.
  task automatic append_bytes(input logic [7:0] bytes [$]);
    foreach (bytes[i]) scan_plan.push_back(bytes[i]);
  endtask

  // Send every planned byte as one request each. Work in bursts of random
  // length; between bursts valid is often dropped for a random gap. Hold valid
  // and the byte steady until the handshake completes.
  task automatic send_plan();
    int unsigned burst_left;
    int unsigned gap;
    logic [7:0]  b;
    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < scan_plan.size(); i++) begin
      b = scan_plan[i];
      if (burst_left == 0) begin
        // Now and then run a long stretch without any gap.
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      in_valid_i  <= 1'b1;
      scan_byte_i <= b;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      board.note_byte(b);
      burst_left--;
    end
    in_valid_i <= 1'b0;
  endtask

  // Receiver: check each accepted result, then pick ready for the next cycle.
  // Switch now and then among stall modes, picked at random: always ready, coin flip,
  // a repeating stall pattern, and mostly stalled.
  int unsigned ready_mode = 0;
  int unsigned ready_cycle = 0;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_event(event_kind_o, key_scan_code_o, key_pressed_o, pulse_event_o);
    ready_cycle <= ready_cycle + 1;
    if (ready_cycle % 200 == 199) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= (ready_cycle % 7) >= 3;
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog: end the run when no handshake happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("timeout: no handshake for %0d cycles, %0d events still pending",
                 IdleLimit, board.pending_count());
        $display("[ps2_set2_scan_code_decoder_top] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0]  pat [$];
    int unsigned pick;
    int unsigned pos;
    int unsigned extra;

    // Directed part: both ends of the byte range as plain makes, a break of
    // a prefix byte, extended make and break, print screen make and break,
    // the full pause sequence and a three-byte prefix that matches nothing.
    append_bytes('{8'h00, 8'hFF});
    append_bytes('{BytePrefixBreak, BytePrefixBreak});
    append_bytes('{BytePrefixExt, 8'hFF});
    append_bytes('{BytePrefixExt, BytePrefixBreak, 8'h00});
    append_bytes('{BytePrefixExt, BytePrtScLead, BytePrefixExt, BytePrtScCode});
    append_bytes('{BytePrefixExt, BytePrefixBreak, BytePrtScCode,
                   BytePrefixExt, BytePrefixBreak, BytePrtScLead});
    append_bytes('{BytePrefixPause, BytePauseCtrl, BytePauseNum, BytePrefixPause,
                   BytePrefixBreak, BytePauseCtrl, BytePrefixBreak, BytePauseNum});
    append_bytes('{BytePrefixPause, 8'h00, 8'h00});

    // Random part: mostly well-formed key sequences with random content,
    // the rest broken long sequences and raw noise.
    while (scan_plan.size() < PlanBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        pat = '{8'($urandom_range(0, 255))};
      end else if (pick < 36) begin
        pat = '{BytePrefixBreak, 8'($urandom_range(0, 255))};
      end else if (pick < 50) begin
        pat = '{BytePrefixExt, 8'($urandom_range(0, 255))};
      end else if (pick < 62) begin
        pat = '{BytePrefixExt, BytePrefixBreak, 8'($urandom_range(0, 255))};
      end else if (pick < 68) begin
        // Print screen make, with filler so the code lands anywhere in n 4..8.
        pat = '{BytePrefixExt, BytePrtScLead, BytePrefixExt};
        extra = $urandom_range(0, 4);
        repeat (extra) pat.push_back(8'($urandom_range(0, 255)));
        pat.push_back(BytePrtScCode);
      end else if (pick < 74) begin
        pat = '{BytePrefixExt, BytePrefixBreak, BytePrtScCode,
                BytePrefixExt, BytePrefixBreak, BytePrtScLead};
      end else if (pick < 80) begin
        pat = '{BytePrefixPause, BytePauseCtrl, BytePauseNum, BytePrefixPause,
                BytePrefixBreak, BytePauseCtrl, BytePrefixBreak, BytePauseNum};
      end else if (pick < 90) begin
        // Broken long sequence: cut short or one byte corrupted.
        if ($urandom_range(0, 1) == 0)
          pat = '{BytePrefixExt, BytePrefixBreak, BytePrtScCode,
                  BytePrefixExt, BytePrefixBreak, BytePrtScLead};
        else
          pat = '{BytePrefixPause, BytePauseCtrl, BytePauseNum, BytePrefixPause,
                  BytePrefixBreak, BytePauseCtrl, BytePrefixBreak, BytePauseNum};
        pos = $urandom_range(1, pat.size() - 1);
        if ($urandom_range(0, 1) == 0) begin
          while (pat.size() > pos) void'(pat.pop_back());
          pat.push_back(8'($urandom_range(0, 255)));
        end else begin
          pat[pos] = 8'($urandom_range(0, 255));
        end
      end else begin
        pat = {};
        extra = $urandom_range(1, 4);
        repeat (extra) pat.push_back(8'($urandom_range(0, 255)));
      end
      append_bytes(pat);
    end

    // Hold reset, then release it once and never assert it again.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_plan();

    // Drain: wait for every pending event, then keep watching the output so that a
    // stray extra result still gets caught.
    while (board.pending_count() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("sent %0d scan bytes, checked %0d events: %0d normal, %0d extended,",
             board.bytes_seen, board.events_checked, board.kind_total[KIND_NORMAL],
             board.kind_total[KIND_EXTENDED]);
    $display("%0d print screen, %0d pause, %0d unknown; %0d mismatches",
             board.kind_total[KIND_PRINT], board.kind_total[KIND_PAUSE],
             board.kind_total[KIND_UNKNOWN], board.mismatches);
    if (board.mismatches == 0 && board.pending_count() == 0) begin
      $display("[ps2_set2_scan_code_decoder_top] OK");
    end else begin
      $display("[ps2_set2_scan_code_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
